// File: rtl/core/cdsp_pkg.sv
// shared constants, codes and word types for the countdown delay slot pool
`default_nettype none
package cdsp_pkg;

	// pool geometry
	localparam int SLOTS = 20;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// fixed field widths
	localparam int MASK_W = 20;
	localparam int DELAY_W = 32;
	localparam int IDX_W = 5;
	localparam int PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

	// operation codes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [DELAY_W-1:0] delay_ticks;
		logic [IDX_W-1:0]   slot_index;
	} req_word_t;

	typedef struct packed {
		logic              alloc_ok;
		logic [IDX_W-1:0]  alloc_slot;
		logic [MASK_W-1:0] done_mask;
		logic [MASK_W-1:0] busy_mask;
		logic              period_flag;
	} rsp_word_t;

	// prescaler commands from the sequencer
	typedef struct packed {
		logic tick;
		logic clear;
	} psc_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/cdsp_count_ram.sv
// slot countdown memory, one write port and one registered read port
`default_nettype none
module cdsp_count_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [cdsp_pkg::SLOT_W-1:0] waddr,
	input  wire logic [cdsp_pkg::DELAY_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [cdsp_pkg::SLOT_W-1:0] raddr,
	output logic      [cdsp_pkg::DELAY_W-1:0] rdata
);
	import cdsp_pkg::*;

	logic [DELAY_W-1:0] mem [SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/cdsp_prescaler.sv
// tick prescaler with period register and sticky period flag
`default_nettype none
module cdsp_prescaler (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cdsp_pkg::PERIOD_W-1:0] cfg_wdata,
	input  wire cdsp_pkg::psc_ctrl_t          ctrl,
	output logic                              flag
);
	import cdsp_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	logic                flag_q;
	logic [PERIOD_W:0]   next_count;
	logic                wrap;

	// count plus one against the period
	assign next_count = {1'b0, count_q} + (PERIOD_W+1)'(1);
	assign wrap = next_count >= {1'b0, period_q};

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// prescale counter and sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q <= 1'b0;
		end else if (ctrl.tick) begin
			if (wrap) begin
				count_q <= '0;
				flag_q <= 1'b1;
			end else begin
				count_q <= next_count[PERIOD_W-1:0];
			end
		end else if (ctrl.clear) begin
			flag_q <= 1'b0;
		end
	end

	assign flag = flag_q;

endmodule
`default_nettype wire

// File: rtl/core/countdown_delay_slot_pool_top.sv
// Countdown delay slot pool: tick walks all slot counts through a one-port-read memory.
// Tick: the walk reads every slot count, then the finish state loads the result register.
// Allocate, release, clear go straight to the finish state; a new item is taken back in idle.
// The next item is taken while a result waits in the output register.
// arst_n clears all slots to free, the prescaler and flag; period resets to 500.
// The count memory needs no clearing pass: counts are only used for slots in use.
`default_nettype none
module countdown_delay_slot_pool_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cdsp_pkg::PERIOD_W-1:0] cfg_wdata,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire cdsp_pkg::req_word_t          req_word,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output cdsp_pkg::rsp_word_t               rsp_word
);
	import cdsp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [SLOT_W-1:0]  rd_idx_s1;
	logic [SLOTS-1:0]   in_use_q;
	logic [SLOTS-1:0]   expired_q;
	logic               ok_q;
	logic [IDX_W-1:0]   slot_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	logic               accept;
	logic               free_any;
	logic [SLOT_W-1:0]  free_idx;
	logic               rd_issue;
	logic               we;
	logic [SLOT_W-1:0]  waddr;
	logic [DELAY_W-1:0] wdata;
	logic [DELAY_W-1:0] rdata;
	logic               rel_ok;
	logic               out_free;
	logic               period_flag;
	psc_ctrl_t          psc_ctrl;
	logic [MASK_W+SLOTS-1:0] busy_wide;
	logic [MASK_W+SLOTS-1:0] done_wide;

	assign accept = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rel_ok = {1'b0, req_word.slot_index} < (IDX_W+1)'(SLOTS);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// walk issues one read per cycle
	assign rd_issue = (state_q == ST_WALK) && (cnt_q < CNT_W'(SLOTS));

	// memory write: allocate load or walk write-back
	always_comb begin
		we = 1'b0;
		waddr = rd_idx_s1;
		wdata = rdata - DELAY_W'(1);
		if (accept && req_word.mode == MODE_ALLOC) begin
			we = free_any;
			waddr = free_idx;
			wdata = req_word.delay_ticks;
		end else if (rd_vld_s1) begin
			we = in_use_q[rd_idx_s1] && (rdata != '0);
		end
	end

	cdsp_count_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_issue),
		.raddr (cnt_q[SLOT_W-1:0]),
		.rdata (rdata)
	);

	// prescaler commands
	assign psc_ctrl.tick = accept && (req_word.mode == MODE_TICK);
	assign psc_ctrl.clear = accept && (req_word.mode == MODE_CLEAR);

	cdsp_prescaler u_psc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (psc_ctrl),
		.flag      (period_flag)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						state_q <= (req_word.mode == MODE_TICK) ? ST_WALK : ST_FIN;
					end
				end
				ST_WALK: begin
					if (rd_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (rd_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read index pipeline
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[SLOT_W-1:0];
	end

	// slot status bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			expired_q <= '0;
		end else if (accept && req_word.mode == MODE_ALLOC) begin
			if (free_any) begin
				in_use_q[free_idx] <= 1'b1;
				expired_q[free_idx] <= 1'b0;
			end
		end else if (accept && req_word.mode == MODE_RELEASE) begin
			if (rel_ok) begin
				in_use_q[req_word.slot_index[SLOT_W-1:0]] <= 1'b0;
				expired_q[req_word.slot_index[SLOT_W-1:0]] <= 1'b0;
			end
		end else if (rd_vld_s1) begin
			if (in_use_q[rd_idx_s1] && (rdata <= DELAY_W'(1))) begin
				expired_q[rd_idx_s1] <= 1'b1;
			end
		end
	end

	// allocation outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= (req_word.mode == MODE_ALLOC) && free_any;
			slot_q <= ((req_word.mode == MODE_ALLOC) && free_any) ? IDX_W'(free_idx) : '0;
		end
	end

	// masks trimmed or padded to the fixed width
	assign busy_wide = {{MASK_W{1'b0}}, in_use_q};
	assign done_wide = {{MASK_W{1'b0}}, expired_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			rsp_q.alloc_ok <= ok_q;
			rsp_q.alloc_slot <= slot_q;
			rsp_q.done_mask <= done_wide[MASK_W-1:0];
			rsp_q.busy_mask <= busy_wide[MASK_W-1:0];
			rsp_q.period_flag <= period_flag;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word = rsp_q;

`ifndef NO_ASSERTIONS
	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(expired_q & ~in_use_q) == '0)
		else $error("slot marked done while free");

	a_walk_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_WALK))
		else $error("walk read data outside the walk");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish state");
`endif

endmodule
`default_nettype wire
